// ===== hdl/gtg_pkg.sv =====
// shared types, constants and the arctangent table for the go-to-goal controller
// no dependencies; imported by every other file in hdl
package gtg_pkg;

	// datapath widths
	localparam int XY_W      = 28;	// cordic x and y, 2^8 scaled position deltas plus growth
	localparam int Z_W       = 25;	// cordic angle, q20 radians
	localparam int E_W       = 26;	// heading error before wrap
	localparam int ATAN_IDX_W = 5;	// table index, 21 nonzero entries
	localparam int MUL_A_W   = 28;
	localparam int MUL_B_W   = 17;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

	// fixed constants
	localparam int PI_Q20       = 3294199;
	localparam int TWO_PI_Q20   = 6588397;
	localparam int INV_GAIN_Q16 = 39797;

	localparam logic [15:0] GAIN_RST  = 16'd4096;
	localparam logic [14:0] DTHR_RST  = 15'd205;
	localparam logic [13:0] ATHR_RST  = 14'd819;

	// register indexes on the configuration port
	localparam logic [1:0] REG_GAIN = 2'd0;
	localparam logic [1:0] REG_DTHR = 2'd1;
	localparam logic [1:0] REG_ATHR = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ITER,
		ST_DIST,
		ST_WRAP1,
		ST_WRAP2,
		ST_SCALE,
		ST_DONE
	} gtg_state_t;

	// sequencer controls for the vectoring unit
	typedef struct packed {
		logic                  load;
		logic                  step;
		logic [ATAN_IDX_W-1:0] idx;
	} cordic_ctrl_t;

	// round(atan(2^-i) * 2^20)
	function automatic logic [19:0] atan_q20(input logic [ATAN_IDX_W-1:0] i);
		logic [19:0] r;
		unique case (i)
			5'd0:    r = 20'd823550;
			5'd1:    r = 20'd486170;
			5'd2:    r = 20'd256879;
			5'd3:    r = 20'd130396;
			5'd4:    r = 20'd65451;
			5'd5:    r = 20'd32757;
			5'd6:    r = 20'd16383;
			5'd7:    r = 20'd8192;
			5'd8:    r = 20'd4096;
			5'd9:    r = 20'd2048;
			5'd10:   r = 20'd1024;
			5'd11:   r = 20'd512;
			5'd12:   r = 20'd256;
			5'd13:   r = 20'd128;
			5'd14:   r = 20'd64;
			5'd15:   r = 20'd32;
			5'd16:   r = 20'd16;
			5'd17:   r = 20'd8;
			5'd18:   r = 20'd4;
			5'd19:   r = 20'd2;
			5'd20:   r = 20'd1;
			default: r = 20'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/gtg_cordic.sv =====
// iterative cordic vectoring unit: one micro-rotation per step
// depends on gtg_pkg for widths, the control struct and the arctangent table
module gtg_cordic import gtg_pkg::*; (
	input  logic                   clk,
	input  cordic_ctrl_t           ctrl,
	input  logic signed [16:0]     dx,
	input  logic signed [16:0]     dy,
	output logic signed [XY_W-1:0] x,
	output logic signed [Z_W-1:0]  z
);

	logic signed [XY_W-1:0] x_q, y_q, x0, y0, xs, ys;
	logic signed [Z_W-1:0]  z_q, a;

	// scale by 2^8 on load
	assign x0 = {{(XY_W-25){dx[16]}}, dx, 8'b0};
	assign y0 = {{(XY_W-25){dy[16]}}, dy, 8'b0};

	assign xs = x_q >>> ctrl.idx;
	assign ys = y_q >>> ctrl.idx;
	assign a  = Z_W'(signed'({1'b0, atan_q20(ctrl.idx)}));

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			// fold the left half-plane onto the right
			if (x0 < 0) begin
				x_q <= -x0;
				y_q <= -y0;
				z_q <= (y0 >= 0) ? Z_W'(PI_Q20) : -Z_W'(PI_Q20);
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end else if (ctrl.step) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + a;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - a;
			end
		end
	end

	assign x = x_q;
	assign z = z_q;

endmodule

// ===== hdl/gtg_mul.sv =====
// shared signed multiplier with registered product
// depends on gtg_pkg for operand widths
module gtg_mul import gtg_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] p
);

	logic signed [MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= MUL_P_W'(a) * MUL_P_W'(b);
		end
	end

	assign p = p_q;

endmodule

// ===== hdl/go_to_goal_p_controller.sv =====
// go-to-goal proportional controller, top level with sequencer and output register
// depends on gtg_pkg, gtg_cordic and gtg_mul
//
// usage
//   input channel (in_valid / in_stall): one beat carries command, pos_x, pos_y, heading.
//   command 0 overwrites the own pose in the beat's cycle and gives no result.
//   command 1 is a target pose and gives exactly one output beat
//   (linear_speed, angular_rate) on the out_valid / out_stall channel.
//   sequence: after a target beat is taken, the sequencer steps through ITER (the
//   cordic steps), DIST (distance product), WRAP1 and WRAP2, SCALE (gain product)
//   and DONE, where the result is loaded into the output register; only then can the
//   block take the next beat. the single cordic rotation stage does one micro-rotation
//   a cycle, and the shared multiplier is used once for the distance and once for the gain.
//   own pose beats are taken one per cycle, back to back, while the block is idle.
//   in_stall is high while a target beat is in work; a result waiting in the
//   output register does not hold off the next input beat. if the receiver
//   still stalls when the next result is ready, the sequencer waits in its
//   last state until the output register frees.
//   reset clears the pose to zero, loads gain 1.0, distance threshold 205 and
//   angle threshold 819, and drops any pending output beat.
//   configuration writes (cfg_write_en, cfg_index, cfg_data) take effect on the
//   next edge; they belong in idle periods only.
module go_to_goal_p_controller import gtg_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_write_en,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// input beat
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [14:0] heading,
	// output beat
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] linear_speed,
	output logic signed [15:0] angular_rate
);

	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

	localparam logic signed [E_W-1:0] PI_E     = E_W'(PI_Q20);
	localparam logic signed [E_W-1:0] TWO_PI_E = E_W'(TWO_PI_Q20);

	gtg_state_t state_q, state_nx;

	// configuration and pose registers
	logic [15:0]        gain_q;
	logic [14:0]        dthr_q;
	logic [13:0]        athr_q;
	logic signed [15:0] own_x_q, own_y_q, own_heading_q;

	logic [STEP_W-1:0]  step_q;
	logic               in_acc, out_free;

	// sequencer outputs
	cordic_ctrl_t       cctl;
	logic               mul_en, mul_sel_gain, e_load, wrap_en, scale_en, out_load;

	// datapath
	logic signed [16:0]        dx, dy;
	logic signed [XY_W-1:0]    cx;
	logic signed [Z_W-1:0]     cz;
	logic signed [E_W-1:0]     e_q, e_new, e_rnd;
	logic signed [17:0]        e12, e_mag;
	logic signed [MUL_P_W-1:0] prod, prod_dist, prod_out;
	logic signed [20:0]        dist_q11;
	logic                      far, turn;
	logic                      turn_q, drive_q;
	logic signed [MUL_A_W-1:0] v_q_in, mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [32:0]        res;
	logic signed [15:0]        res_sat;

	logic                      out_valid_q;
	logic signed [15:0]        lin_q, ang_q;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_acc && command) state_nx = ST_ITER;
			ST_ITER:  if (step_q == LAST_STEP) state_nx = ST_DIST;
			ST_DIST:  state_nx = ST_WRAP1;
			ST_WRAP1: state_nx = ST_WRAP2;
			ST_WRAP2: state_nx = ST_SCALE;
			ST_SCALE: state_nx = ST_DONE;
			ST_DONE:  if (out_free) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall     = 1'b1;
		cctl.load    = 1'b0;
		cctl.step    = 1'b0;
		cctl.idx     = ATAN_IDX_W'(step_q);
		mul_en       = 1'b0;
		mul_sel_gain = 1'b0;
		e_load       = 1'b0;
		wrap_en      = 1'b0;
		scale_en     = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// never stalled in idle, so a valid beat is taken here
				in_stall  = 1'b0;
				cctl.load = in_valid && command;
			end
			ST_ITER:  cctl.step = 1'b1;
			ST_DIST: begin
				mul_en = 1'b1;
				e_load = 1'b1;
			end
			ST_WRAP1, ST_WRAP2: wrap_en = 1'b1;
			ST_SCALE: begin
				mul_en       = 1'b1;
				mul_sel_gain = 1'b1;
				scale_en     = 1'b1;
			end
			ST_DONE:  out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (cctl.step) begin
				step_q <= (step_q == LAST_STEP) ? '0 : step_q + 1'b1;
			end else if (cctl.load) begin
				step_q <= '0;
			end
		end
	end

	// configuration registers, high bits of cfg_data dropped for narrow ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RST;
			dthr_q <= DTHR_RST;
			athr_q <= ATHR_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_GAIN: gain_q <= cfg_data;
				REG_DTHR: dthr_q <= cfg_data[14:0];
				REG_ATHR: athr_q <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	// own pose, overwritten by command 0 beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_x_q       <= '0;
			own_y_q       <= '0;
			own_heading_q <= '0;
		end else if (in_acc && !command) begin
			own_x_q       <= pos_x;
			own_y_q       <= pos_y;
			own_heading_q <= {heading[14], heading};
		end
	end

	// exact 17 bit deltas to the target
	assign dx = {pos_x[15], pos_x} - {own_x_q[15], own_x_q};
	assign dy = {pos_y[15], pos_y} - {own_y_q[15], own_y_q};

	gtg_cordic u_cordic (
		.clk  (clk),
		.ctrl (cctl),
		.dx   (dx),
		.dy   (dy),
		.x    (cx),
		.z    (cz)
	);

	// shared multiplier: distance scaling first, then the gain
	assign mul_a = mul_sel_gain ? v_q_in : cx;
	assign mul_b = mul_sel_gain ? MUL_B_W'(signed'({1'b0, gain_q}))
	                            : MUL_B_W'(INV_GAIN_Q16);

	gtg_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// heading error in q20, then one wrap correction per pass
	assign e_new = E_W'(cz) - {{2{own_heading_q[15]}}, own_heading_q, 8'b0};

	always_ff @(posedge clk) begin
		if (e_load) begin
			e_q <= e_new;
		end else if (wrap_en) begin
			if (e_q > PI_E) begin
				e_q <= e_q - TWO_PI_E;
			end else if (e_q < -PI_E) begin
				e_q <= e_q + TWO_PI_E;
			end
		end
	end

	// round q20 error to q12
	assign e_rnd = e_q + E_W'(128);
	assign e12   = e_rnd[E_W-1:8];
	assign e_mag = e12[17] ? -e12 : e12;

	// distance in q10.11 from the scaled cordic magnitude
	assign prod_dist = prod + MUL_P_W'(64'sd8388608);
	assign dist_q11  = prod_dist[MUL_P_W-1:24];

	assign far  = dist_q11 > signed'({6'b0, dthr_q});
	assign turn = e_mag > signed'({4'b0, athr_q});

	// operand for the gain product: error when turning, distance when driving, zero when near
	always_comb begin
		if (far && turn) begin
			v_q_in = MUL_A_W'(e12);
		end else if (far) begin
			v_q_in = MUL_A_W'(dist_q11);
		end else begin
			v_q_in = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (scale_en) begin
			turn_q  <= far && turn;
			drive_q <= far && !turn;
		end
	end

	// round the q12 gain and saturate to 16 bits
	assign prod_out = prod + MUL_P_W'(2048);
	assign res      = prod_out[MUL_P_W-1:12];

	always_comb begin
		if (res > 33'sd32767) begin
			res_sat = 16'sh7fff;
		end else if (res < -33'sd32768) begin
			res_sat = 16'sh8000;
		end else begin
			res_sat = res[15:0];
		end
	end

	// output register, frees the sequencer from the receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			lin_q <= drive_q ? res_sat : '0;
			ang_q <= turn_q  ? res_sat : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign linear_speed = lin_q;
	assign angular_rate = ang_q;

endmodule

// ===== tb/tb_go_to_goal_p_controller.sv =====
// self-checking testbench for the go-to-goal proportional controller
// holds a scoreboard class with its own bit-exact predictor of the velocity command
// depends on gtg_pkg and go_to_goal_p_controller from hdl
`timescale 1ns / 1ps

localparam int CORDIC_ITERS = 16;

typedef struct packed {
	logic signed [15:0] lin;
	logic signed [15:0] ang;
} vel_cmd_t;

class vel_cmd_scoreboard;
	localparam longint PI_Q20 = 3294199;
	localparam longint TWO_PI_Q20 = 6588397;
	localparam longint INV_GAIN_Q16 = 39797;

	vel_cmd_t           awaited_cmds[$];
	logic signed [15:0] own_x, own_y, own_hdg;
	logic [15:0]        gain;
	logic [14:0]        dist_thr;
	logic [13:0]        ang_thr;
	longint             atan_tab[24];
	int                 failures;

	function new();
		own_x = 0;
		own_y = 0;
		own_hdg = 0;
		gain = gtg_pkg::GAIN_RST;
		dist_thr = gtg_pkg::DTHR_RST;
		ang_thr = gtg_pkg::ATHR_RST;
		failures = 0;
		atan_tab = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
			4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};
	endfunction

	function void write_reg(logic [1:0] idx, logic [15:0] val);
		case (idx)
			gtg_pkg::REG_GAIN: gain = val;
			gtg_pkg::REG_DTHR: dist_thr = val[14:0];
			gtg_pkg::REG_ATHR: ang_thr = val[13:0];
			default: ;
		endcase
	endfunction

	function logic signed [15:0] clamp16(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	// distance and bearing by vectoring, then the proportional law
	function vel_cmd_t steer_to_target(logic signed [15:0] tx, logic signed [15:0] ty);
		longint   x, y, z, xs, ys, e, e12, dist_q11, mag;
		int       n;
		vel_cmd_t cmd;
		x = (longint'(tx) - longint'(own_x)) * 256;
		y = (longint'(ty) - longint'(own_y)) * 256;
		z = 0;
		cmd.lin = 0;
		cmd.ang = 0;
		if (x < 0) begin
			z = (y >= 0) ? PI_Q20 : -PI_Q20;
			x = -x;
			y = -y;
		end
		n = (CORDIC_ITERS > 24) ? 24 : CORDIC_ITERS;
		for (int i = 0; i < n; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys;
				y -= xs;
				z += atan_tab[i];
			end else begin
				x -= ys;
				y += xs;
				z -= atan_tab[i];
			end
		end
		dist_q11 = (x * INV_GAIN_Q16 + 8388608) >>> 24;
		e = z - longint'(own_hdg) * 256;
		repeat (2) if (e > PI_Q20) e -= TWO_PI_Q20;
		repeat (2) if (e < -PI_Q20) e += TWO_PI_Q20;
		e12 = (e + 128) >>> 8;
		if (dist_q11 > longint'(dist_thr)) begin
			mag = (e12 < 0) ? -e12 : e12;
			if (mag > longint'(ang_thr))
				cmd.ang = clamp16((longint'(gain) * e12 + 2048) >>> 12);
			else
				cmd.lin = clamp16((longint'(gain) * dist_q11 + 2048) >>> 12);
		end
		return cmd;
	endfunction

	function void note_input(bit cmd, logic signed [15:0] x, logic signed [15:0] y,
			logic signed [14:0] h);
		if (cmd == 1'b0) begin
			own_x = x;
			own_y = y;
			own_hdg = h;
		end else begin
			awaited_cmds.push_back(steer_to_target(x, y));
		end
	endfunction

	function void log_failure(string msg);
		failures++;
		if (failures <= 10)
			$display("%s", msg);
	endfunction

	function void check_output(logic signed [15:0] lin, logic signed [15:0] ang);
		vel_cmd_t exp_cmd;
		if (awaited_cmds.size() == 0) begin
			log_failure($sformatf("unexpected result beat: lin %0d ang %0d", lin, ang));
			return;
		end
		exp_cmd = awaited_cmds.pop_front();
		if (lin !== exp_cmd.lin)
			log_failure($sformatf("linear_speed wrong: expected %0d, got %0d",
				exp_cmd.lin, lin));
		if (ang !== exp_cmd.ang)
			log_failure($sformatf("angular_rate wrong: expected %0d, got %0d",
				exp_cmd.ang, ang));
	endfunction
endclass

module tb_go_to_goal_p_controller;
	import gtg_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3;	// unmapped index, must be ignored
	localparam bit POSE_UPDATE = 1'b0;
	localparam bit TARGET_POSE = 1'b1;
	localparam int SETTLE_CYCLES = CORDIC_ITERS + 10;
	localparam int CYCLE_LIMIT = 500000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_write_en;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic               command;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [14:0] heading;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] linear_speed;
	logic signed [15:0] angular_rate;

	vel_cmd_scoreboard sb;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycle_count = 0;

	go_to_goal_p_controller #(.CORDIC_STEPS(CORDIC_ITERS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.heading(heading),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.linear_speed(linear_speed),
		.angular_rate(angular_rate)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// both channels are observed with pre-edge values, so the scoreboard sees
	// exactly the beats the block takes and gives
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_input(command, pos_x, pos_y, heading);
		if (arst_n && out_valid && !out_stall)
			sb.check_output(linear_speed, angular_rate);
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("go_to_goal_p_controller: mismatch");
			$finish;
		end
	end

	// present one beat, with random idle cycles first, and return at the edge that takes it
	task automatic send_beat(input bit cmd, input int x, input int y, input int h);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		pos_x <= x[15:0];
		pos_y <= y[15:0];
		heading <= h[14:0];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// hold the sender off until every awaited command has come back
	task automatic pause_until_answered();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited_cmds.size() != 0)
			@(posedge clk);
	endtask

	// quiet period before a register write or the end of the run; own-pose beats
	// give no result, so an extra settling wait covers anything still in flight
	task automatic drain();
		pause_until_answered();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// all three registers plus a write to the unmapped index; upper bits of the
	// narrow registers carry noise that the block must mask off
	task automatic apply_settings(input logic [15:0] g, input logic [14:0] dt,
			input logic [13:0] at);
		logic [1:0]  idx[4] = '{REG_GAIN, REG_DTHR, REG_ATHR, REG_SPARE};
		logic [15:0] val[4];
		val = '{g, {1'($urandom), dt}, {2'($urandom), at}, 16'($urandom)};
		for (int i = 0; i < 4; i++) begin
			cfg_write_en <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			sb.write_reg(idx[i], val[i]);
			@(posedge clk);
		end
		cfg_write_en <= 1'b0;
	endtask

	initial begin
		int          span, tx, ty;
		bit          cmd;
		logic [15:0] g;
		logic [14:0] dt;
		logic [13:0] at;
		int          idle_plan[4] = '{0, 50, 0, 14};
		int          stall_plan[4] = '{0, 0, 50, 14};

		sb = new();
		arst_n <= 1'b0;
		cfg_write_en <= 1'b0;
		cfg_index <= REG_GAIN;
		cfg_data <= '0;
		in_valid <= 1'b0;
		command <= POSE_UPDATE;
		pos_x <= '0;
		pos_y <= '0;
		heading <= '0;
		out_stall <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset register values
		send_beat(TARGET_POSE, 0, 0, 0);		// target on own position
		send_beat(TARGET_POSE, 100, 50, 0);		// inside distance threshold
		send_beat(TARGET_POSE, 4096, 0, 0);		// dead ahead, drive
		send_beat(TARGET_POSE, 0, 4096, 5000);	// left, turn; heading field ignored
		send_beat(TARGET_POSE, -4096, 0, 0);	// behind, folded to +pi
		send_beat(TARGET_POSE, -4096, -1, 0);	// behind, folded to -pi
		send_beat(POSE_UPDATE, 32767, 32767, 12868);
		send_beat(TARGET_POSE, -32768, -32768, 0);	// widest delta, error wraps
		send_beat(POSE_UPDATE, -32768, -32768, -12868);
		send_beat(TARGET_POSE, 32767, 32767, -12868);
		send_beat(TARGET_POSE, 32767, -32768, 0);
		drain();

		// highest gain, zero thresholds: saturation both ways
		apply_settings(16'hffff, 15'd0, 14'd0);
		send_beat(POSE_UPDATE, 0, 0, 0);
		send_beat(TARGET_POSE, 32767, 0, 0);
		send_beat(TARGET_POSE, 0, -32768, 0);
		send_beat(TARGET_POSE, 1, 0, 0);
		drain();

		// zero gain, top thresholds: angle threshold above pi so only driving
		apply_settings(16'h0000, 15'h7fff, 14'd12868);
		send_beat(TARGET_POSE, -32768, -32768, 0);
		send_beat(POSE_UPDATE, 32767, 32767, 0);
		send_beat(TARGET_POSE, -32768, -32768, 0);
		drain();

		apply_settings(16'd4096, 15'h7fff, 14'd12868);
		send_beat(TARGET_POSE, -32768, -32768, 0);
		drain();

		// random part: four idling phases, two register settings in each
		for (int p = 0; p < 8; p++) begin
			g = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(8191));
			dt = ($urandom_range(3) == 0) ? 15'($urandom) : 15'($urandom_range(3000));
			at = 14'($urandom_range(12868));
			apply_settings(g, dt, at);
			sender_idle_pct = idle_plan[p / 2];
			recv_stall_pct = stall_plan[p / 2];
			for (int n = 0; n < 125; n++) begin
				// mostly targets near the own pose so thresholds are crossed both ways
				span = 1 << $urandom_range(15, 1);
				cmd = ($urandom_range(99) < 30) ? POSE_UPDATE : TARGET_POSE;
				if ($urandom_range(3) == 0) begin
					tx = int'($urandom);
					ty = int'($urandom);
				end else begin
					tx = int'(sb.own_x) + int'($urandom_range(2 * span)) - span;
					ty = int'(sb.own_y) + int'($urandom_range(2 * span)) - span;
				end
				if (n == 60 || $urandom_range(39) == 0)
					pause_until_answered();
				send_beat(cmd, tx, ty, int'($urandom_range(25736)) - 12868);
			end
			drain();
		end

		if (sb.failures == 0 && sb.awaited_cmds.size() == 0)
			$display("go_to_goal_p_controller: match");
		else
			$display("go_to_goal_p_controller: mismatch");
		$finish;
	end

endmodule
